// ===== src/ltbp_pkg.sv =====
// Shared constants, code tables and types for the LZSS token bit packer.
// No dependencies; all other files but ltbp_ram and ltbp_byte_if use this package.
package ltbp_pkg;

  localparam int SYMBOL_COUNT       = 314;
  localparam int MIN_MATCH_LESS_ONE = 2;
  localparam int MAX_CODE_LEN       = 16;

  localparam int ADDR_W   = $clog2(SYMBOL_COUNT);
  localparam int SYM_W    = ADDR_W + 1;
  localparam int SYM_BASE = 255 - MIN_MATCH_LESS_ONE;

  localparam int KIND_W   = 2;
  localparam int LIT_W    = 8;
  localparam int MLEN_W   = 6;
  localparam int MOFF_W   = 12;
  localparam int EIDX_W   = 9;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int ENTRY_W  = CODE_W + LEN_W;
  localparam int POS_HI_W = 6;
  localparam int POS_LO_W = 6;
  localparam int PLEN_W   = 4;

  localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd3;

  localparam int FIX_LIT_LEN   = 9;
  localparam int FIX_MATCH_LEN = 7;

  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_USE_TABLE = 1'd0;

  localparam int CHUNK_W = 32;
  localparam int NBITS_W = 6;
  localparam int WIN_W   = CHUNK_W + 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [PLEN_W-1:0] POS_LEN [64] = '{
    4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
  };

  localparam logic [7:0] POS_CODE [64] = '{
    8'h00, 8'h20, 8'h30, 8'h40, 8'h50, 8'h58, 8'h60, 8'h68,
    8'h70, 8'h78, 8'h80, 8'h88, 8'h90, 8'h94, 8'h98, 8'h9C,
    8'hA0, 8'hA4, 8'hA8, 8'hAC, 8'hB0, 8'hB4, 8'hB8, 8'hBC,
    8'hC0, 8'hC2, 8'hC4, 8'hC6, 8'hC8, 8'hCA, 8'hCC, 8'hCE,
    8'hD0, 8'hD2, 8'hD4, 8'hD6, 8'hD8, 8'hDA, 8'hDC, 8'hDE,
    8'hE0, 8'hE2, 8'hE4, 8'hE6, 8'hE8, 8'hEA, 8'hEC, 8'hEE,
    8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
    8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  typedef struct packed {
    logic               flush;
    logic [NBITS_W-1:0] nbits;
    logic [CHUNK_W-1:0] bits;
  } chunk_t;

endpackage

// ===== src/ltbp_token_if.sv =====
// Token channel: valid/ready handshake with the token fields.
// Depends on ltbp_pkg for field widths.
interface ltbp_token_if;
  logic                            valid;
  logic                            ready;
  logic [ltbp_pkg::KIND_W-1:0]     kind;
  logic [ltbp_pkg::LIT_W-1:0]      literal_byte;
  logic [ltbp_pkg::MLEN_W-1:0]     copy_length;
  logic [ltbp_pkg::MOFF_W-1:0]     match_offset;
  logic [ltbp_pkg::EIDX_W-1:0]     entry_index;
  logic [ltbp_pkg::CODE_W-1:0]     entry_code;
  logic [ltbp_pkg::LEN_W-1:0]      entry_bits;

  modport source (
    output valid, kind, literal_byte, copy_length, match_offset,
           entry_index, entry_code, entry_bits,
    input  ready
  );
  modport sink (
    input  valid, kind, literal_byte, copy_length, match_offset,
           entry_index, entry_code, entry_bits,
    output ready
  );
endinterface

// ===== src/ltbp_byte_if.sv =====
// Result channel: valid/ready handshake carrying one packed byte and last.
// Depends on ltbp_pkg by convention only; widths are fixed bytes.
interface ltbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ===== src/ltbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/ltbp_front.sv =====
// Front end: accepts tokens, loads the prefix table, looks up symbol codes and builds
// one left-justified bit chunk per non-load token. Uses ltbp_pkg, ltbp_ram.
module ltbp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             use_table,
  ltbp_token_if.sink       tok,
  input  logic             q_full,
  output logic             push,
  output ltbp_pkg::chunk_t push_data
);
  import ltbp_pkg::*;

  logic               acc;
  logic               is_load;
  logic [SYM_W-1:0]   sym_full;
  logic               sym_ok;
  logic [ADDR_W-1:0]  rd_addr;
  logic               we;
  logic [LEN_W-1:0]   wr_len;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               s1_valid;
  logic [KIND_W-1:0]  s1_kind;
  logic [LIT_W-1:0]   s1_lit;
  logic [MLEN_W-1:0]  s1_mlen;
  logic [MOFF_W-1:0]  s1_moff;
  logic               s1_sym_ok;

  logic [CODE_W-1:0]   tcode;
  logic [LEN_W-1:0]    tlen;
  logic [CODE_W-1:0]   sym_code;
  logic [LEN_W-1:0]    sym_len;
  logic [POS_HI_W-1:0] pos_hi;
  logic [POS_LO_W-1:0] pos_lo;
  logic [7:0]          pcode;
  logic [PLEN_W-1:0]   plen;
  logic [NBITS_W-1:0]  lo_shift;

  assign tok.ready = !rst && (!s1_valid || !q_full);
  assign acc       = tok.valid && tok.ready;
  assign is_load   = (tok.kind == KIND_LOAD);
  assign push      = s1_valid && !q_full;

  assign sym_full = SYM_W'(SYM_BASE) + SYM_W'(tok.copy_length);

  always_comb begin
    if (tok.kind == KIND_MATCH) begin
      sym_ok  = (sym_full < SYM_W'(SYMBOL_COUNT));
      rd_addr = sym_ok ? sym_full[ADDR_W-1:0] : '0;
    end else begin
      sym_ok  = 1'b1;
      rd_addr = ADDR_W'(tok.literal_byte);
    end
  end

  assign we     = acc && is_load && ({1'b0, tok.entry_index} < (EIDX_W + 1)'(SYMBOL_COUNT));
  assign wr_len = (tok.entry_bits > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                          : tok.entry_bits;

  ltbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (tok.entry_index[ADDR_W-1:0]),
    .wdata ({tok.entry_code, wr_len}),
    .re    (acc && !is_load),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc && !is_load) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !is_load) begin
      s1_kind   <= tok.kind;
      s1_lit    <= tok.literal_byte;
      s1_mlen   <= tok.copy_length;
      s1_moff   <= tok.match_offset;
      s1_sym_ok <= sym_ok;
    end
  end

  assign tcode  = ram_rdata[ENTRY_W-1:LEN_W];
  assign tlen   = ram_rdata[LEN_W-1:0];
  assign pos_hi = s1_moff[MOFF_W-1:POS_LO_W];
  assign pos_lo = s1_moff[POS_LO_W-1:0];
  assign pcode  = POS_CODE[pos_hi];
  assign plen   = POS_LEN[pos_hi];

  always_comb begin
    if (use_table) begin
      sym_len  = s1_sym_ok ? tlen : '0;
      sym_code = tcode & ~({CODE_W{1'b1}} >> sym_len);
    end else if (s1_kind == KIND_MATCH) begin
      sym_len  = LEN_W'(FIX_MATCH_LEN);
      sym_code = {1'b1, s1_mlen, 9'b0};
    end else begin
      sym_len  = LEN_W'(FIX_LIT_LEN);
      sym_code = {1'b0, s1_lit, 7'b0};
    end
  end

  assign lo_shift = NBITS_W'(sym_len) + NBITS_W'(plen);

  always_comb begin
    push_data = '0;
    case (s1_kind)
      KIND_LITERAL: begin
        push_data.bits  = {sym_code, 16'b0};
        push_data.nbits = NBITS_W'(sym_len);
      end
      KIND_MATCH: begin
        push_data.bits  = {sym_code, 16'b0}
                        | ({pcode, 24'b0} >> sym_len)
                        | ({pos_lo, 26'b0} >> lo_shift);
        push_data.nbits = lo_shift + NBITS_W'(POS_LO_W);
      end
      default: begin
        push_data.flush = 1'b1;
      end
    endcase
  end
endmodule

// ===== src/ltbp_queue.sv =====
// Short chunk queue between the front and back ends.
// Depends on ltbp_pkg for chunk_t and the queue depth.
module ltbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ltbp_pkg::chunk_t push_data,
  output logic             full,
  input  logic             pop,
  output ltbp_pkg::chunk_t pop_data,
  output logic             empty
);
  import ltbp_pkg::*;

  chunk_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end
endmodule

// ===== src/ltbp_back.sv =====
// Back end: merges chunks into the pending bit accumulator and streams complete bytes
// out one per cycle while the result sink is ready. Depends on ltbp_pkg, ltbp_byte_if.
module ltbp_back (
  input  logic             clk,
  input  logic             rst,
  input  ltbp_pkg::chunk_t head,
  input  logic             q_empty,
  output logic             pop,
  ltbp_byte_if.source      res
);
  import ltbp_pkg::*;

  logic [7:0]         pend_byte;
  logic [2:0]         pend_cnt;
  logic [WIN_W-1:0]   win;
  logic [2:0]         bytes_left;
  logic               ovalid;
  logic [7:0]         obyte;
  logic               olast;

  logic               emit;
  logic [NBITS_W-1:0] total;
  logic [WIN_W-1:0]   merged;
  logic [WIN_W-1:0]   win_next;
  logic [2:0]         nb_next;
  logic [2:0]         pend_cnt_next;
  logic [7:0]         pend_byte_next;

  assign res.valid    = ovalid;
  assign res.out_byte = obyte;
  assign res.last     = olast;

  assign emit = (!ovalid || res.ready) && (bytes_left != 3'd0);
  assign pop  = !q_empty && ((bytes_left == 3'd0) || ((bytes_left == 3'd1) && emit));

  assign total  = NBITS_W'(pend_cnt) + head.nbits;
  assign merged = {pend_byte, {CHUNK_W{1'b0}}} | ({head.bits, 8'b0} >> pend_cnt);

  always_comb begin
    if (head.flush) begin
      win_next       = {pend_byte, {CHUNK_W{1'b0}}};
      nb_next        = (pend_cnt != 3'd0) ? 3'd1 : 3'd0;
      pend_cnt_next  = 3'd0;
      pend_byte_next = 8'd0;
    end else begin
      win_next      = merged;
      nb_next       = total[5:3];
      pend_cnt_next = total[2:0];
      case (total[5:3])
        3'd0:    pend_byte_next = merged[39:32];
        3'd1:    pend_byte_next = merged[31:24];
        3'd2:    pend_byte_next = merged[23:16];
        3'd3:    pend_byte_next = merged[15:8];
        default: pend_byte_next = merged[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid     <= 1'b0;
      bytes_left <= 3'd0;
      pend_cnt   <= 3'd0;
      pend_byte  <= 8'd0;
    end else begin
      if (emit) begin
        ovalid <= 1'b1;
      end else if (res.ready) begin
        ovalid <= 1'b0;
      end
      if (pop) begin
        bytes_left <= nb_next;
        pend_cnt   <= pend_cnt_next;
        pend_byte  <= pend_byte_next;
      end else if (emit) begin
        bytes_left <= bytes_left - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte <= win[WIN_W-1 -: 8];
      olast <= (bytes_left == 3'd1);
    end
    if (pop) begin
      win <= win_next;
    end else if (emit) begin
      win <= {win[WIN_W-9:0], 8'b0};
    end
  end
endmodule

// ===== src/lzss_token_bit_packer_unit.sv =====
// LZSS token bit packer top level: APB mode register, front end, queue, back end.
// The first byte of a token passes through the front-end stage register, the queue,
// the byte window and the output register. The back end emits one byte per cycle
// while the result sink is ready, and a token holds it until its bytes are out.
// Synchronous reset clears the mode, accumulator, queue and output; the prefix
// table is undefined until loaded.
module lzss_token_bit_packer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ltbp_pkg::PADDR_W-1:0]   paddr,
  input  logic [ltbp_pkg::DATA_W-1:0]    pwdata,
  output logic [ltbp_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  ltbp_token_if.sink                     tok,
  ltbp_byte_if.source                    res
);
  import ltbp_pkg::*;

  logic   use_table;
  logic   cfg_wr;
  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  chunk_t push_data;
  chunk_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[PADDR_W-1:2] == REG_USE_TABLE);
  assign prdata = (paddr[PADDR_W-1:2] == REG_USE_TABLE) ? DATA_W'(use_table) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_table <= 1'b0;
    end else if (cfg_wr) begin
      use_table <= pwdata[0];
    end
  end

  ltbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .use_table (use_table),
    .tok       (tok),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ltbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  ltbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .res     (res)
  );
endmodule

// ===== src/ltbp_checker.sv =====
// Port-level checks for the LZSS token bit packer, bound to the top level.
// Depends on ltbp_pkg and lzss_token_bit_packer_unit.
module ltbp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [ltbp_pkg::PADDR_W-1:0] paddr,
  input logic [ltbp_pkg::DATA_W-1:0]  pwdata,
  input logic [ltbp_pkg::DATA_W-1:0]  prdata,
  input logic                         pready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [7:0]                   res_out_byte,
  input logic                         res_last
);
  import ltbp_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_out_byte) && $stable(res_last))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_USE_TABLE))
    ##1 (paddr[PADDR_W-1:2] == REG_USE_TABLE)
    |-> prdata[0] == $past(pwdata[0]))
    else $error("mode register readback mismatch");
endmodule

bind lzss_token_bit_packer_unit ltbp_checker u_ltbp_checker (
  .clk          (clk),
  .rst          (rst),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_out_byte (res.out_byte),
  .res_last     (res.last)
);

// ===== tb/tb_lzss_token_bit_packer_unit.sv =====
// Testbench for lzss_token_bit_packer_unit: drives tokens and APB mode writes and
// predicts every packed byte. Checks each byte and its last flag in order.
// Depends on ltbp_pkg, ltbp_token_if and ltbp_byte_if from the RTL.
`timescale 1ns / 100ps

module tb_lzss_token_bit_packer_unit;
  import ltbp_pkg::*;

  localparam int MATCH_SYM_BASE = 255 - MIN_MATCH_LESS_ONE;
  localparam int DRAIN_CYCLES   = 12;
  localparam int IDLE_PCT       = 22;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LIT_W-1:0]  literal_byte;
    logic [MLEN_W-1:0] copy_length;
    logic [MOFF_W-1:0] match_offset;
    logic [EIDX_W-1:0] entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_bits;
  } token_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } packed_byte_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  ltbp_token_if tok_if ();
  ltbp_byte_if  byte_if ();

  lzss_token_bit_packer_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tok     (tok_if),
    .res     (byte_if)
  );

  // encoder state mirrored from the block
  logic [15:0]  acc_bits;
  logic [2:0]   acc_count;
  bit           table_mode;
  logic [15:0]  sym_code [SYMBOL_COUNT];
  logic [4:0]   sym_len [SYMBOL_COUNT];
  bit           sym_loaded [SYMBOL_COUNT];
  int unsigned  lit_pool [$];
  int unsigned  len_pool [$];
  logic [7:0]   token_bytes [$];
  packed_byte_t pending_bytes [$];

  int  err_count;
  int  bytes_checked;
  int  n_literal;
  int  n_match;
  int  n_flush;
  int  n_load;
  int  hold_off;
  bit  steady_stream;
  bit  offering;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void append_bits(input int unsigned nbits, input logic [15:0] code);
    logic [31:0] win;
    logic [15:0] kept;
    int unsigned n;
    int unsigned total;
    n = (nbits > MAX_CODE_LEN) ? MAX_CODE_LEN : nbits;
    if (n != 0) begin
      kept = code & (16'hFFFF << (16 - n));
      win = {acc_bits, 16'h0000} | ({16'h0000, kept} << (16 - acc_count));
      total = acc_count + n;
      while (total >= 8) begin
        token_bytes.push_back(win[31:24]);
        win = win << 8;
        total = total - 8;
      end
      acc_bits = win[31:16];
      acc_count = total[2:0];
    end
  endfunction

  function automatic void emit_symbol(input int unsigned sym);
    if (sym < SYMBOL_COUNT) append_bits(sym_len[sym], sym_code[sym]);
  endfunction

  function automatic void position_prefix(input logic [5:0] hi, output int unsigned len,
                                          output logic [7:0] code);
    if (hi == 0) begin
      len = 3;
      code = 8'h00;
    end else if (hi < 4) begin
      len = 4;
      code = 8'((hi + 1) << 4);
    end else if (hi < 12) begin
      len = 5;
      code = 8'(8'h50 + (hi - 4) * 8);
    end else if (hi < 24) begin
      len = 6;
      code = 8'(8'h90 + (hi - 12) * 4);
    end else if (hi < 48) begin
      len = 7;
      code = 8'(8'hC0 + (hi - 24) * 2);
    end else begin
      len = 8;
      code = 8'(8'hF0 + (hi - 48));
    end
  endfunction

  function automatic void encode_token(input token_t t);
    int unsigned plen;
    logic [7:0]  pcode;
    int unsigned idx;
    packed_byte_t pb;
    token_bytes.delete();
    case (t.kind)
      KIND_LITERAL: begin
        if (table_mode) emit_symbol(t.literal_byte);
        else append_bits(FIX_LIT_LEN, {1'b0, t.literal_byte, 7'b0});
      end
      KIND_MATCH: begin
        if (table_mode) emit_symbol(MATCH_SYM_BASE + t.copy_length);
        else append_bits(FIX_MATCH_LEN, {1'b1, t.copy_length, 9'b0});
        position_prefix(t.match_offset[11:6], plen, pcode);
        append_bits(plen, {pcode, 8'h00});
        append_bits(6, {t.match_offset[5:0], 10'b0});
      end
      KIND_FLUSH: begin
        if (acc_count != 0) token_bytes.push_back(acc_bits[15:8]);
        acc_bits = '0;
        acc_count = '0;
      end
      default: begin
        idx = t.entry_index;
        if (idx < SYMBOL_COUNT) begin
          sym_code[idx] = t.entry_code;
          sym_len[idx] = LEN_W'((t.entry_bits > MAX_CODE_LEN) ? MAX_CODE_LEN
                                                              : t.entry_bits);
          if (!sym_loaded[idx]) begin
            sym_loaded[idx] = 1'b1;
            if (idx < 256) lit_pool.push_back(idx);
            if (idx >= MATCH_SYM_BASE) len_pool.push_back(idx - MATCH_SYM_BASE);
          end
        end
      end
    endcase
    foreach (token_bytes[i]) begin
      pb.out_byte = token_bytes[i];
      pb.last = (i == token_bytes.size() - 1);
      pending_bytes.push_back(pb);
    end
  endfunction

  function automatic token_t token_of(input logic [KIND_W-1:0] kind, input int lit,
                                      input int mlen, input int moff, input int eidx,
                                      input int ecode, input int ebits);
    token_t t;
    t.kind = kind;
    t.literal_byte = LIT_W'(lit);
    t.copy_length = MLEN_W'(mlen);
    t.match_offset = MOFF_W'(moff);
    t.entry_index = EIDX_W'(eidx);
    t.entry_code = CODE_W'(ecode);
    t.entry_bits = LEN_W'(ebits);
    return t;
  endfunction

  function automatic token_t random_token(input bit force_match);
    token_t t;
    int unsigned r;
    r = force_match ? 50 : $urandom_range(99);
    t.literal_byte = LIT_W'($urandom);
    t.copy_length = MLEN_W'($urandom);
    t.match_offset = MOFF_W'($urandom);
    t.entry_code = CODE_W'($urandom);
    t.entry_bits = LEN_W'(($urandom_range(99) < 25) ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 16));
    t.entry_index = EIDX_W'(($urandom_range(99) < 80) ? $urandom_range(0, SYMBOL_COUNT - 1)
                                                      : $urandom_range(SYMBOL_COUNT, 511));
    if (r < 45) begin
      t.kind = KIND_LITERAL;
      if (table_mode && !sym_loaded[t.literal_byte])
        t.literal_byte = LIT_W'(lit_pool[$urandom_range(lit_pool.size() - 1)]);
    end else if (r < 80) begin
      t.kind = KIND_MATCH;
      if (table_mode && MATCH_SYM_BASE + t.copy_length < SYMBOL_COUNT &&
          !sym_loaded[MATCH_SYM_BASE + t.copy_length])
        t.copy_length = MLEN_W'(len_pool[$urandom_range(len_pool.size() - 1)]);
    end else if (r < 88) begin
      t.kind = KIND_FLUSH;
    end else begin
      t.kind = KIND_LOAD;
    end
    return t;
  endfunction

  task automatic send_token(input token_t t);
    if (!steady_stream && $urandom_range(99) < IDLE_PCT) begin
      if (offering) begin
        tok_if.valid <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    tok_if.valid        <= 1'b1;
    tok_if.kind         <= t.kind;
    tok_if.literal_byte <= t.literal_byte;
    tok_if.copy_length  <= t.copy_length;
    tok_if.match_offset <= t.match_offset;
    tok_if.entry_index  <= t.entry_index;
    tok_if.entry_code   <= t.entry_code;
    tok_if.entry_bits   <= t.entry_bits;
    offering = 1'b1;
    do @(posedge clk); while (!tok_if.ready);
    encode_token(t);
    case (t.kind)
      KIND_LITERAL: n_literal++;
      KIND_MATCH:   n_match++;
      KIND_FLUSH:   n_flush++;
      default:      n_load++;
    endcase
  endtask

  task automatic wait_for_results();
    if (offering) begin
      tok_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic set_mode(input bit value);
    logic [DATA_W-1:0] rdata;
    logic [PADDR_W-1:0] addr;
    addr = {REG_USE_TABLE, 2'b00};
    wait_for_results();
    apb_access(1'b1, addr, {{(DATA_W - 1){1'b0}}, value}, rdata);
    apb_access(1'b0, addr, '0, rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (rdata !== {{(DATA_W - 1){1'b0}}, value})
      report_mismatch($sformatf("mode readback %0h, wrote %0d", rdata, value));
    table_mode = value;
  endtask

  task automatic test_fixed_directed();
    send_token(token_of(KIND_LITERAL, 8'h00, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_LITERAL, 8'hFF, 63, 4095, 511, 16'hFFFF, 31));
    send_token(token_of(KIND_LITERAL, 8'hA5, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 0, 12'h000, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 63, 12'hFFF, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 3, 12'h040, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 17, 12'h115, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 40, 12'h32A, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 9, 12'h63F, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 21, 12'hC01, 0, 0, 0));
    send_token(token_of(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_LOAD, 0, 0, 0, 511, 16'hFFFF, 31));
    send_token(token_of(KIND_LOAD, 0, 0, 0, 314, 16'h1234, 4));
    send_token(token_of(KIND_LITERAL, 8'h5A, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_mode_register();
    set_mode(1'b1);
    set_mode(1'b0);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_token(random_token(1'b0));
  endtask

  task automatic test_table_directed();
    set_mode(1'b1);
    // low code bits beyond the length must be dropped
    send_token(token_of(KIND_LOAD, 0, 0, 0, 0, 16'hFFFF, 3));
    // lengths above the maximum saturate
    send_token(token_of(KIND_LOAD, 0, 0, 0, 255, 16'hB6D5, 31));
    send_token(token_of(KIND_LOAD, 0, 0, 0, 65, 16'hFFFF, 0));
    send_token(token_of(KIND_LOAD, 0, 0, 0, MATCH_SYM_BASE, 16'h8000, 1));
    send_token(token_of(KIND_LOAD, 0, 0, 0, SYMBOL_COUNT - 1, 16'hFFFF, 16));
    send_token(token_of(KIND_LOAD, 0, 0, 0, 400, 16'h0F0F, 7));
    send_token(token_of(KIND_LOAD, 0, 0, 0, SYMBOL_COUNT, 16'hFFFF, 9));
    send_token(token_of(KIND_LITERAL, 8'h00, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_LITERAL, 8'hFF, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_LITERAL, 8'h41, 0, 0, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 0, 12'hFFF, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, SYMBOL_COUNT - 1 - MATCH_SYM_BASE, 12'h000, 0, 0, 0));
    // symbols past the table send only the position
    send_token(token_of(KIND_MATCH, 0, SYMBOL_COUNT - MATCH_SYM_BASE, 12'h7FF, 0, 0, 0));
    send_token(token_of(KIND_MATCH, 0, 63, 12'h07B, 0, 0, 0));
    send_token(token_of(KIND_FLUSH, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_steady_stream(input int count);
    steady_stream = 1'b1;
    test_random(count);
    steady_stream = 1'b0;
  endtask

  task automatic test_backpressure(input int count);
    hold_off = 120;
    repeat (count) send_token(random_token(1'b1));
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_if.ready <= 1'b0;
    end else if (hold_off != 0) begin
      byte_if.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      byte_if.ready <= steady_stream || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : byte_check
    packed_byte_t want;
    if (!rst && byte_if.valid && byte_if.ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", byte_if.out_byte,
                                  byte_if.last));
      end else begin
        want = pending_bytes.pop_front();
        if (byte_if.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h", byte_if.out_byte,
                                    want.out_byte));
        if (byte_if.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b on byte %02h", byte_if.last,
                                    want.last, want.out_byte));
      end
    end
  end

  initial begin
    int n;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    tok_if.valid     <= 1'b0;
    tok_if.kind      <= KIND_LITERAL;
    tok_if.literal_byte <= '0;
    tok_if.copy_length  <= '0;
    tok_if.match_offset <= '0;
    tok_if.entry_index  <= '0;
    tok_if.entry_code   <= '0;
    tok_if.entry_bits   <= '0;
    acc_bits = '0;
    acc_count = '0;
    table_mode = 1'b0;
    hold_off = 0;
    steady_stream = 1'b0;
    offering = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fixed_directed();
    test_mode_register();
    test_random(80);
    test_table_directed();
    test_random(65);
    test_steady_stream(40);
    test_backpressure(24);
    set_mode(1'b0);
    test_random(40);

    if (offering) begin
      tok_if.valid <= 1'b0;
      offering = 1'b0;
    end
    for (n = 0; n < 5000 && pending_bytes.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));

    $display("Sent %0d tokens: %0d literals, %0d matches, %0d flushes, %0d table loads.",
             n_literal + n_match + n_flush + n_load, n_literal, n_match, n_flush, n_load);
    $display("Checked %0d bytes in fixed and prefix-table modes under stalls and backpressure.",
             bytes_checked);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
